@@ rtl/core/string_bucket_hash_unit_defines.svh @@
// Assertion macros shared by the string bucket hash RTL.
`ifndef STRING_BUCKET_HASH_UNIT_DEFINES_SVH
`define STRING_BUCKET_HASH_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define SBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define SBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SBH_ASSERT(lbl, prop, msg)
`define SBH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/sbh_pkg.sv @@
// Types and constants for the string bucket hash unit.
package sbh_pkg;

  // Field widths
  localparam int unsigned CharW = 8;
  localparam int unsigned HashW = 32;
  localparam int unsigned LenW  = 31;

  // Hash arithmetic
  localparam int unsigned HashBase   = 13;
  localparam int unsigned CharOffset = 97;  // lower-case 'a'

  // Queue between front and back (depth must be a power of two)
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Divider step count
  localparam int unsigned DivCntW = $clog2(HashW);

  // Configuration port
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegSelB = 2;  // paddr bit that selects the register word
  localparam logic        RegLenSel = 1'b0;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } sbh_q_stat_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } sbh_back_state_e;

endpackage

@@ rtl/core/sbh_front.sv @@
// Front end: takes character transfers and keeps the running base-13 hash.
module sbh_front
  import sbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [CharW-1:0]   char_code_i,
  output logic               in_stall_o,
  input  sbh_q_stat_t        q_stat_i,
  output logic               q_push_o,
  output logic [HashW-1:0]   q_data_o
);

  logic [HashW-1:0] hash_q;
  logic [HashW-1:0] hash_d;
  logic             accept;
  logic             term;

  // Stall only while the queue cannot take a finished string
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign term       = (char_code_i == '0);

  // Terminator hands the current hash to the back end
  assign q_push_o = accept && term;
  assign q_data_o = hash_q;

  // hash*13 + c - 'a', wrapping at 32 bits; cleared on terminator
  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      if (term) begin
        hash_d = '0;
      end else begin
        hash_d = hash_q * HashW'(HashBase) + HashW'(char_code_i) - HashW'(CharOffset);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

@@ rtl/core/sbh_queue.sv @@
// Short queue of finished string hashes between front and back.
module sbh_queue
  import sbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [HashW-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [HashW-1:0]   pop_data_o,
  output sbh_q_stat_t        stat_o
);

  logic [HashW-1:0] entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/sbh_back.sv @@
// Back end: restoring divider for hash modulo length, plus output register.
module sbh_back
  import sbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LenW-1:0]    len_i,
  input  sbh_q_stat_t        q_stat_i,
  input  logic [HashW-1:0]   q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  output logic [LenW-1:0]    bucket_o,
  input  logic               out_stall_i
);

  sbh_back_state_e   state_q, state_d;
  logic [HashW-1:0]  quo_q, quo_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [LenW-1:0]   bucket_q, bucket_d;

  logic              out_free;
  logic [HashW-1:0]  trial;
  logic [HashW-1:0]  diff;
  logic              fits;
  logic [LenW-1:0]   rem_step;

  assign out_free = !out_valid_q || !out_stall_i;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial    = {rem_q, quo_q[HashW-1]};
  assign diff     = trial - HashW'(len_i);
  assign fits     = (trial >= HashW'(len_i));
  assign rem_step = fits ? diff[LenW-1:0] : trial[LenW-1:0];

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    bucket_d    = bucket_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          quo_d   = q_data_i;
          rem_d   = '0;
          cnt_d   = DivCntW'(HashW - 1);
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        quo_d = quo_q << 1;
        rem_d = rem_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (out_free) begin
            bucket_d    = rem_step;
            out_valid_d = 1'b1;
            state_d     = BK_IDLE;
          end else begin
            state_d = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          bucket_d    = rem_q;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    bucket_q <= bucket_d;
  end

  assign out_valid_o = out_valid_q;
  assign bucket_o    = bucket_q;

endmodule

@@ rtl/core/string_bucket_hash_unit.sv @@
// Flow: a terminator's hash is queued, popped and divided, and its bucket registered.
// Throughput: one character per cycle while not stalled; the 32-step restoring divider
// in the back end takes one string at a time, a two-entry queue absorbs bursts.
// Reset (rst_ni low, asynchronous): hash and queue cleared, divider idle,
// no result pending, table_length back to 1.
// Top level of the string bucket hash unit.
`include "string_bucket_hash_unit_defines.svh"

module string_bucket_hash_unit
  import sbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // character channel
  input  logic               in_valid_i,
  input  logic [CharW-1:0]   char_code_i,
  output logic               in_stall_o,
  // bucket channel
  output logic               out_valid_o,
  output logic [LenW-1:0]    bucket_o,
  input  logic               out_stall_i,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  len_eff;
  logic             cfg_wr;
  sbh_q_stat_t      q_stat;
  logic             q_push;
  logic             q_pop;
  logic [HashW-1:0] q_wdata;
  logic [HashW-1:0] q_rdata;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[RegSelB] == RegLenSel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
    end else if (cfg_wr) begin
      len_q <= pwdata[LenW-1:0];
    end
  end

  assign prdata  = (paddr[RegSelB] == RegLenSel) ? DataW'(len_q) : '0;
  // A zero length acts as one
  assign len_eff = (len_q == '0) ? LenW'(1) : len_q;

  sbh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .in_stall_o  (in_stall_o),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  sbh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  sbh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_eff),
    .q_stat_i    (q_stat),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .bucket_o    (bucket_o),
    .out_stall_i (out_stall_i)
  );

  // Checks
  `SBH_ASSERT(a_bucket_in_range, !out_valid_o || (bucket_o < len_eff), "bucket not below table length")
  `SBH_ASSERT(a_no_push_full, !(q_push && q_stat.full), "push into full queue")
  `SBH_ASSERT(a_term_queued, (in_valid_i && !in_stall_o && (char_code_i == '0)) |=> !q_stat.empty, "terminator lost")

endmodule
